>>> hdl/dqs_pkg.sv
// Shared types and codes for the double-ended queue with search and delete.
// Used by dqs_cell, dqs_find and deque_with_search_and_delete; no dependencies.

package dqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_ctl_t;

endpackage

>>> hdl/dqs_cell.sv
// One storage cell of the queue row: holds one entry and compares it with the key.
// Depends on dqs_pkg.

module dqs_cell (
  input  logic                               clk,
  input  dqs_pkg::cell_ctl_t                 ctl,
  input  logic signed [dqs_pkg::DATA_W-1:0]  key,
  input  logic signed [dqs_pkg::DATA_W-1:0]  left_data,
  input  logic signed [dqs_pkg::DATA_W-1:0]  right_data,
  output logic signed [dqs_pkg::DATA_W-1:0]  data,
  output logic                               match
);
  import dqs_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctl)
      CELL_LOAD:       data_nxt = key;
      CELL_FROM_LEFT:  data_nxt = left_data;
      CELL_FROM_RIGHT: data_nxt = right_data;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

>>> hdl/dqs_find.sv
// Locates the first and the last set bit of the cell match vector.
// Log-depth prefix OR, then one-hot to index. Depends on dqs_pkg.

module dqs_find #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
  input  logic [DEPTH-1:0]         match,
  output logic                     found,
  output logic [$clog2(DEPTH)-1:0] first_idx,
  output logic [$clog2(DEPTH)-1:0] last_idx
);
  import dqs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LVLS  = $clog2(DEPTH);

  logic [DEPTH-1:0] lo [LVLS+1];
  logic [DEPTH-1:0] hi [LVLS+1];
  logic [DEPTH-1:0] first_oh;
  logic [DEPTH-1:0] last_oh;

  always_comb begin
    lo[0] = match;
    hi[0] = match;
    for (int l = 0; l < LVLS; l++) begin
      lo[l+1] = lo[l] | (lo[l] << (1 << l));
      hi[l+1] = hi[l] | (hi[l] >> (1 << l));
    end
    // keep only the match with nothing matching below / above it
    first_oh = match & ~(lo[LVLS] << 1);
    last_oh  = match & ~(hi[LVLS] >> 1);
  end

  always_comb begin
    first_idx = '0;
    last_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_oh[i]) first_idx = first_idx | IDX_W'(i);
      if (last_oh[i])  last_idx  = last_idx  | IDX_W'(i);
    end
  end

  assign found = |match;

endmodule

>>> hdl/deque_with_search_and_delete.sv
// Bounded double-ended queue of signed 32-bit values with search and delete.
// Each item is registered on accept; the execute step then runs the compare-and-shift
// step of the cell row and registers the result, waiting while a stalled output still
// holds the previous result. A new item is taken only once the pending one has executed.
// Reset (rst_n low, synchronous): entry count and control cleared; cell contents kept.
// Depends on dqs_pkg, dqs_cell and dqs_find.

module deque_with_search_and_delete #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dqs_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [dqs_pkg::DATA_W-1:0]   in_value,
  input  logic                                in_from_head,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dqs_pkg::STAT_W-1:0]          out_status,
  output logic signed [dqs_pkg::DATA_W-1:0]   out_popped_value,
  output logic [dqs_pkg::POS_W-1:0]           out_position,
  output logic [dqs_pkg::POS_W-1:0]           out_entry_count
);
  import dqs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic             busy_r;      // an accepted item waits for its execute step
  logic [CNT_W-1:0] count_r;     // number of live entries, head in cell 0
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;

  // Request held from accept to execute; the value doubles as the cell key
  logic [REQ_W-1:0]         req_r;
  logic signed [DATA_W-1:0] value_r;
  logic                     from_head_r;

  // Result register
  logic [STAT_W-1:0]        status_r;
  logic [STAT_W-1:0]        status_nxt;
  logic signed [DATA_W-1:0] popped_r;
  logic signed [DATA_W-1:0] popped_nxt;
  logic [POS_W-1:0]         pos_r;
  logic [POS_W-1:0]         pos_nxt;
  logic [POS_W-1:0]         entry_cnt_r;

  logic accept;
  logic exec;

  // Take a new item whenever no item is pending; the output register parts the
  // two sides, so a stalled result blocks acceptance only once an item is pending.
  assign in_stall = busy_r;
  assign accept   = in_valid && !in_stall;
  // Execute once the output register is free or being emptied this cycle.
  assign exec     = busy_r && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  cell_ctl_t                cell_ctl  [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_match;
  logic [DEPTH-1:0]         live_match;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (g == 0) begin : g_head
      assign left_d = value_r;
    end else begin : g_body_l
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_d = cell_data[g];
    end else begin : g_body_r
      assign right_d = cell_data[g+1];
    end

    dqs_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .key        (value_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );

    // ignore cells past the tail
    assign live_match[g] = cell_match[g] && (CNT_W'(g) < count_r);
  end

  logic             found;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] last_idx;

  dqs_find #(.DEPTH(DEPTH)) u_find (
    .match     (live_match),
    .found     (found),
    .first_idx (first_idx),
    .last_idx  (last_idx)
  );

  // Tail entry, picked by AND-OR over the row
  logic signed [DATA_W-1:0] tail_val;

  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == count_r) tail_val = tail_val | cell_data[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Execute step: decode the held request into cell moves and the result
  // ---------------------------------------------------------------------------
  logic is_full;
  logic is_empty;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    popped_nxt = '0;
    pos_nxt    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i] = CELL_HOLD;
    end

    unique case (req_r)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          // advance every entry one cell towards the tail, load the head
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == count_r) cell_ctl[i] = CELL_LOAD;
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = cell_data[0];
          for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i] = CELL_FROM_RIGHT;
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = tail_val;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      REQ_SEARCH: begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else if (from_head_r) begin
          pos_nxt = POS_W'(CNT_W'(first_idx) + CNT_W'(1));
        end else begin
          pos_nxt = POS_W'(count_r - CNT_W'(last_idx));
        end
      end
      REQ_DELETE: begin
        if (!found) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          // close the gap: entries from the first match onwards move headwards
          for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) >= first_idx) cell_ctl[i] = CELL_FROM_RIGHT;
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase

    // hold the row unless this is the execute cycle
    if (!exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_ctl[i] = CELL_HOLD;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (exec) begin
        busy_r <= 1'b0;
      end
      if (exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= in_req_type;
      value_r     <= in_value;
      from_head_r <= in_from_head;
    end
    if (exec) begin
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
      pos_r       <= pos_nxt;
      entry_cnt_r <= POS_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_position     = pos_r;
  assign out_entry_count  = entry_cnt_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond queue depth");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r && !busy_r)
    else $error("execute step did not load the result register");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (req_r == REQ_CLEAR) |=> (count_r == '0) && (out_entry_count == '0))
    else $error("clear left entries behind");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (status_nxt == ST_EMPTY) |=> $stable(count_r) && (out_popped_value == '0))
    else $error("pop on empty queue changed state or returned data");

endmodule
